/* src/hpw_pkg.sv */
// shared constants and types for the heading pid controller
package hpw_pkg;

  // field and state widths
  localparam int HEADING_W = 16;
  localparam int ERR_W     = 17;
  localparam int SUM_W     = 32;
  localparam int DER_W     = 18;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 15;
  localparam int DRIVE_W   = 16;
  localparam int CFG_IDX_W = 2;

  // angle constants in 1/64 degree
  localparam logic signed [ERR_W-1:0] HALF_TURN = 17'sd11520;
  localparam logic signed [ERR_W-1:0] FULL_TURN = 17'sd23040;

  // q8.8 gain times 1/64 degree error
  localparam int SCALE_SHIFT = 14;

  // register reset values
  localparam logic signed [GAIN_W-1:0] GAIN_PROP_RESET  = -16'sd6400;
  localparam logic signed [GAIN_W-1:0] GAIN_INTEG_RESET = 16'sd0;
  localparam logic signed [GAIN_W-1:0] GAIN_DERIV_RESET = 16'sd0;
  localparam logic [LIMIT_W-1:0]       LIMIT_RESET      = 15'd400;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROP   = 2'd0,
    CFG_GAIN_INTEG  = 2'd1,
    CFG_GAIN_DERIV  = 2'd2,
    CFG_DRIVE_LIMIT = 2'd3
  } cfg_reg_t;

  // error terms handed from the tracking stage to the mixing stage
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [SUM_W-1:0] sum;
    logic signed [DER_W-1:0] der;
  } track_t;

endpackage

/* src/hpw_track.sv */
// heading error fold, saturating integral and derivative with state registers
module hpw_track (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  logic signed [hpw_pkg::HEADING_W-1:0]  heading_now,
  input  logic signed [hpw_pkg::HEADING_W-1:0]  heading_goal,
  output hpw_pkg::track_t                       stage
);

  logic signed [hpw_pkg::ERR_W-1:0] last_error;
  logic signed [hpw_pkg::SUM_W-1:0] error_sum;

  logic signed [hpw_pkg::ERR_W-1:0] diff;
  logic signed [hpw_pkg::ERR_W-1:0] err;
  logic signed [hpw_pkg::SUM_W:0]   sum_wide;
  logic signed [hpw_pkg::SUM_W-1:0] sum_sat;
  logic signed [hpw_pkg::DER_W-1:0] der;

  // fold the error onto the shorter way round
  always_comb begin
    diff = hpw_pkg::ERR_W'(heading_goal) - hpw_pkg::ERR_W'(heading_now);
    if (diff > hpw_pkg::HALF_TURN) begin
      err = hpw_pkg::FULL_TURN - diff;
    end else if (diff < -hpw_pkg::HALF_TURN) begin
      err = -hpw_pkg::FULL_TURN - diff;
    end else begin
      err = -diff;
    end
  end

  // saturating integral and derivative
  always_comb begin
    sum_wide = (hpw_pkg::SUM_W+1)'(error_sum) + (hpw_pkg::SUM_W+1)'(err);
    if (sum_wide[hpw_pkg::SUM_W] != sum_wide[hpw_pkg::SUM_W-1]) begin
      sum_sat = sum_wide[hpw_pkg::SUM_W] ? {1'b1, {(hpw_pkg::SUM_W-1){1'b0}}}
                                         : {1'b0, {(hpw_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[hpw_pkg::SUM_W-1:0];
    end
    der = hpw_pkg::DER_W'(err) - hpw_pkg::DER_W'(last_error);
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum  <= '0;
    end else if (load) begin
      last_error <= err;
      error_sum  <= sum_sat;
    end
  end

  // stage register toward the mixing logic
  always_ff @(posedge clk) begin
    if (load) begin
      stage.err <= err;
      stage.sum <= sum_sat;
      stage.der <= der;
    end
  end

endmodule

/* src/heading_pid_with_wrap.sv */
// top level of the heading pid controller with angle wrap
//
// Two-stage pipeline that accepts one heading transaction per clock while
// it is not stalled by the output side, and returns one drive value per
// transaction. The drive value passes from the stage register into the
// result register once the output register is free or being taken. The
// first stage folds the heading error, updates the saturating integral and
// the previous error, and registers error, integral and derivative; the
// second stage forms Kp*e + Ki*I + Kd*d with three parallel multipliers,
// floors the sum by 2^14, clamps it above by drive_upper_limit and below at
// -32768, and registers the result. A held result in the output register
// does not block a new transaction from entering an empty first stage.
// Configuration writes take effect on the next clock and should be made only while the pipeline is empty.
module heading_pid_with_wrap (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [hpw_pkg::HEADING_W-1:0]  heading_now,
  input  logic signed [hpw_pkg::HEADING_W-1:0]  heading_goal,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [hpw_pkg::DRIVE_W-1:0]    drive,
  input  logic                                  cfg_we,
  input  logic [hpw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hpw_pkg::GAIN_W-1:0]            cfg_data
);

  localparam int ACC_W    = 50;
  localparam int SCALED_W = ACC_W - hpw_pkg::SCALE_SHIFT;

  logic signed [hpw_pkg::GAIN_W-1:0] gain_prop;
  logic signed [hpw_pkg::GAIN_W-1:0] gain_integ;
  logic signed [hpw_pkg::GAIN_W-1:0] gain_deriv;
  logic [hpw_pkg::LIMIT_W-1:0]       drive_upper_limit;

  logic            s1_valid;
  logic            s1_ready;
  logic            adv_out;
  logic            load;
  hpw_pkg::track_t stage;

  logic signed [32:0]                     p_prop;
  logic signed [47:0]                     p_integ;
  logic signed [33:0]                     p_deriv;
  logic signed [ACC_W-1:0]                acc;
  logic signed [SCALED_W-1:0]             scaled;
  logic signed [hpw_pkg::DRIVE_W-1:0]     drive_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop         <= hpw_pkg::GAIN_PROP_RESET;
      gain_integ        <= hpw_pkg::GAIN_INTEG_RESET;
      gain_deriv        <= hpw_pkg::GAIN_DERIV_RESET;
      drive_upper_limit <= hpw_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (hpw_pkg::cfg_reg_t'(cfg_index))
        hpw_pkg::CFG_GAIN_PROP:   gain_prop  <= cfg_data;
        hpw_pkg::CFG_GAIN_INTEG:  gain_integ <= cfg_data;
        hpw_pkg::CFG_GAIN_DERIV:  gain_deriv <= cfg_data;
        hpw_pkg::CFG_DRIVE_LIMIT: drive_upper_limit <= cfg_data[hpw_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign adv_out  = !out_valid || out_ready;
  assign s1_ready = !s1_valid || adv_out;
  assign in_ready = s1_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (adv_out) begin
        out_valid <= s1_valid;
      end
    end
  end

  // error tracking stage
  hpw_track u_track (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .heading_now  (heading_now),
    .heading_goal (heading_goal),
    .stage        (stage)
  );

  // weighted sum, floor shift and clamp
  always_comb begin
    p_prop  = gain_prop * stage.err;
    p_integ = gain_integ * stage.sum;
    p_deriv = gain_deriv * stage.der;
    acc     = ACC_W'(p_prop) + ACC_W'(p_integ) + ACC_W'(p_deriv);
    scaled  = acc[ACC_W-1:hpw_pkg::SCALE_SHIFT];
    if (scaled > $signed({{(SCALED_W-hpw_pkg::LIMIT_W){1'b0}}, drive_upper_limit})) begin
      drive_next = $signed({1'b0, drive_upper_limit});
    end else if (scaled < -(SCALED_W'(32768))) begin
      drive_next = {1'b1, {(hpw_pkg::DRIVE_W-1){1'b0}}};
    end else begin
      drive_next = scaled[hpw_pkg::DRIVE_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv_out && s1_valid) begin
      drive <= drive_next;
    end
  end

`ifndef SYNTHESIS
  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  // a first-stage transaction moves into a free output register
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && adv_out |=> out_valid)
    else $error("stage one transaction lost");

  // a stalled output keeps the first stage occupied
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && s1_valid |=> s1_valid && $stable(stage))
    else $error("stage one changed under stall");

  // the input is refused only while both stages are full
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid)
    else $error("input refused with room in the pipeline");
`endif

endmodule

/* sim/tb_heading_pid_with_wrap.sv */
// self-checking testbench for the heading pid controller with angle wrap
`timescale 1ns / 1ps

module tb_heading_pid_with_wrap;
  import hpw_pkg::*;

  localparam int     STUCK_LIMIT   = 2000;
  localparam int     MAX_PRINTED   = 50;
  localparam int     WINDUP_FEED   = 20;
  localparam longint SUM_MAX       = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_MIN       = -(longint'(1) <<< (SUM_W - 1));
  localparam longint DRIVE_MIN     = -(longint'(1) <<< (DRIVE_W - 1));

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [HEADING_W-1:0]   heading_now;
  logic signed [HEADING_W-1:0]   heading_goal;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [DRIVE_W-1:0]     drive;
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [GAIN_W-1:0]             cfg_data;

  // controller state and register copies kept by the predictor
  logic signed [GAIN_W-1:0]      kp_q88 = GAIN_PROP_RESET;
  logic signed [GAIN_W-1:0]      ki_q88 = GAIN_INTEG_RESET;
  logic signed [GAIN_W-1:0]      kd_q88 = GAIN_DERIV_RESET;
  logic [LIMIT_W-1:0]            drive_cap = LIMIT_RESET;
  longint                        prev_err = 0;
  longint                        err_integral = 0;

  logic signed [DRIVE_W-1:0]     drive_expect_q[$];
  int                            err_count = 0;
  int                            stuck_cycles = 0;
  int                            sink_hold = 0;
  bit                            fast_mode = 1'b0;

  heading_pid_with_wrap u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .heading_now  (heading_now),
    .heading_goal (heading_goal),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive        (drive),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // fold, integrate, differentiate and mix one heading sample
  function automatic logic signed [DRIVE_W-1:0] predict_drive(
    input logic signed [HEADING_W-1:0] now_v,
    input logic signed [HEADING_W-1:0] goal_v
  );
    longint n, g, d, e, s, dv, acc, res;
    n = now_v;
    g = goal_v;
    d = g - n;
    // take the shorter way round when more than half a turn apart
    if (d > longint'(HALF_TURN) || d < -longint'(HALF_TURN)) begin
      if (g > n) e = longint'(FULL_TURN) - g + n;
      else e = -(longint'(FULL_TURN) + g - n);
    end else begin
      e = n - g;
    end
    s = err_integral + e;
    if (s > SUM_MAX) s = SUM_MAX;
    if (s < SUM_MIN) s = SUM_MIN;
    err_integral = s;
    dv = e - prev_err;
    prev_err = e;
    acc = longint'(kp_q88) * e + longint'(ki_q88) * s + longint'(kd_q88) * dv;
    // arithmetic shift floors toward minus infinity
    res = acc >>> SCALE_SHIFT;
    if (res > longint'(drive_cap)) res = longint'(drive_cap);
    if (res < DRIVE_MIN) res = DRIVE_MIN;
    return res[DRIVE_W-1:0];
  endfunction

  task automatic flag_error(input string msg);
    if (err_count < MAX_PRINTED) $display("ERROR: %s", msg);
    err_count++;
  endtask

  // watch both channels: check results, predict accepted headings, watchdog
  always @(posedge clk) begin : observe
    logic signed [DRIVE_W-1:0] want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (drive_expect_q.size() == 0) begin
          flag_error($sformatf("drive %0d with no transaction pending", drive));
        end else begin
          want = drive_expect_q.pop_front();
          if (drive !== want)
            flag_error($sformatf("drive %0d, expected %0d", drive, want));
        end
      end
      if (in_valid && in_ready)
        drive_expect_q.push_back(predict_drive(heading_now, heading_goal));
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("FAIL heading_pid_with_wrap");
          $finish;
        end
      end
    end
  end

  // result sink with random stalls and an optional long hold-off
  initial begin : drive_sink
    int stall;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (sink_hold > 0) begin
        out_ready <= 1'b0;
        repeat (sink_hold) @(negedge clk);
        sink_hold = 0;
      end
      stall = fast_mode ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // offer one heading transaction; entered and left at a falling edge
  task automatic send_heading(input logic signed [HEADING_W-1:0] now_v,
                              input logic signed [HEADING_W-1:0] goal_v);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    heading_now  <= now_v;
    heading_goal <= goal_v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering and wait until every drive value is back
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (drive_expect_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [GAIN_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_GAIN_PROP:   kp_q88 = val;
      CFG_GAIN_INTEG:  ki_q88 = val;
      CFG_GAIN_DERIV:  kd_q88 = val;
      CFG_DRIVE_LIMIT: drive_cap = val[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // load all four registers; only called with the pipeline drained
  task automatic configure(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                           input logic [GAIN_W-1:0] kd, input logic [GAIN_W-1:0] lim);
    write_reg(CFG_GAIN_PROP, kp);
    write_reg(CFG_GAIN_INTEG, ki);
    write_reg(CFG_GAIN_DERIV, kd);
    write_reg(CFG_DRIVE_LIMIT, lim);
    cfg_we <= 1'b0;
  endtask

  // mostly in-range headings, with wrap edges, equal pairs and full-width noise
  task automatic send_random_heading();
    int now_i, goal_i, pick, span;
    span   = int'(FULL_TURN) + int'(HALF_TURN);
    pick   = $urandom_range(0, 9);
    now_i  = int'($urandom_range(0, span)) - int'(HALF_TURN);
    goal_i = int'($urandom_range(0, span)) - int'(HALF_TURN);
    case (pick)
      6, 7: begin
        goal_i = int'(HALF_TURN) + int'($urandom_range(0, 4)) - 2;
        goal_i = $urandom_range(0, 1) ? now_i + goal_i : now_i - goal_i;
      end
      8: begin
        now_i  = int'($urandom_range(0, 65535)) - 32768;
        goal_i = int'($urandom_range(0, 65535)) - 32768;
      end
      9: goal_i = now_i;
      default: ;
    endcase
    send_heading(HEADING_W'(now_i), HEADING_W'(goal_i));
  endtask

  // reset gains: range ends, half-turn boundary, fold both ways, floor rounding
  task automatic test_reset_gains();
    send_heading(0, 0);
    send_heading(100, 0);
    send_heading(-100, 0);
    send_heading(-11520, 23040);
    send_heading(23040, -11520);
    send_heading(0, 11520);
    send_heading(0, 11521);
    send_heading(11521, 0);
    send_heading(-11520, -11520);
    send_heading(32767, -32768);
    send_heading(-32768, 32767);
  endtask

  // gain and limit extremes, upper clamp and lower saturation
  task automatic test_gain_extremes();
    drain_pipeline();
    configure(16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF);
    send_heading(-32768, 32767);
    send_heading(32767, -32768);
    drain_pipeline();
    configure(16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
    send_heading(100, 0);
    send_heading(-100, 0);
    send_heading(-11520, 23040);
    drain_pipeline();
    configure(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
    send_heading(5, 0);
  endtask

  // derivative term alone, including the widest error swing
  task automatic test_derivative_path();
    drain_pipeline();
    configure(16'h0000, 16'h0000, 16'sd512, 16'h7FFF);
    send_heading(0, 0);
    send_heading(1000, 0);
    send_heading(-1000, 0);
    send_heading(32767, -32768);
    send_heading(-32768, 32767);
    send_heading(0, 0);
  endtask

  // sink holds off long enough for the pipeline to fill and stall the input
  task automatic test_output_backpressure();
    drain_pipeline();
    configure(-16'sd6400, 16'sd2, 16'sd300, 16'sd400);
    fast_mode = 1'b1;
    sink_hold = 300;
    repeat (40) send_random_heading();
    fast_mode = 1'b0;
  endtask

  // random headings over several register settings
  task automatic test_random_traffic();
    int phase;
    logic [GAIN_W-1:0] kp, ki, kd, lim;
    for (phase = 0; phase < 8; phase++) begin
      drain_pipeline();
      case (phase % 4)
        0: begin
          kp  = GAIN_W'(int'($urandom_range(0, 4000)) - 2000);
          ki  = GAIN_W'(int'($urandom_range(0, 16)) - 8);
          kd  = GAIN_W'(int'($urandom_range(0, 2000)) - 1000);
          lim = GAIN_W'($urandom_range(0, 32767));
        end
        1: begin
          kp  = GAIN_W'($urandom());
          ki  = GAIN_W'($urandom());
          kd  = GAIN_W'($urandom());
          lim = GAIN_W'($urandom());
        end
        2: begin
          kp  = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          ki  = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          kd  = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          lim = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
        end
        default: begin
          kp  = -16'sd6400;
          ki  = GAIN_W'($urandom_range(0, 4));
          kd  = GAIN_W'($urandom_range(0, 600));
          lim = 16'sd400;
        end
      endcase
      configure(kp, ki, kd, lim);
      // every third phase runs back to back on both sides
      fast_mode = (phase % 3 == 2);
      repeat (200) send_random_heading();
    end
    fast_mode = 1'b0;
  endtask

  // wind the integral up hard one way and then the other, so the drive
  // hits the upper clamp and then the lower saturation
  task automatic test_integral_windup();
    drain_pipeline();
    configure(16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF);
    fast_mode = 1'b1;
    repeat (WINDUP_FEED) send_heading(32767, -32768);
    repeat (2 * WINDUP_FEED) send_heading(-32768, 32767);
    send_heading(0, 0);
    fast_mode = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    heading_now  = '0;
    heading_goal = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_GAIN_PROP;
    cfg_data     = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_reset_gains();
    test_gain_extremes();
    test_derivative_path();
    test_output_backpressure();
    test_random_traffic();
    test_integral_windup();

    drain_pipeline();
    repeat (8) @(negedge clk);
    if (err_count == 0) begin
      $display("PASS heading_pid_with_wrap");
    end else begin
      $display("FAIL heading_pid_with_wrap");
    end
    $finish;
  end

endmodule
